/* design/sst_pkg.sv */
package sst_pkg;

    typedef enum logic [2:0] {
        CMD_NOTE    = 3'd0,
        CMD_CONFIRM = 3'd1,
        CMD_MARK    = 3'd2,
        CMD_CHECK   = 3'd3,
        CMD_QUERY   = 3'd4,
        CMD_EXPIRE  = 3'd5
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DISPATCH,
        ST_DERIVE,
        ST_COPY,
        ST_STREAM,
        ST_EXPIRE,
        ST_RESULT
    } t_state;

    localparam logic [1:0] PH_INIT  = 2'd0;
    localparam logic [1:0] PH_PLAIN = 2'd1;
    localparam logic [1:0] PH_DICT  = 2'd2;
    localparam logic [1:0] PH_SECURE = 2'd3;

    localparam logic [1:0] TV_ACCEPT = 2'd0;
    localparam logic [1:0] TV_REPLAY = 2'd1;
    localparam logic [1:0] TV_ORDER  = 2'd2;

    localparam logic [31:0] LCG_MUL = 32'd1664525;
    localparam logic [31:0] LCG_ADD = 32'd1013904223;
    localparam logic [31:0] EXPIRE_DEFAULT = 32'd86400;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] session_id;
        logic [63:0] message_ts;
        logic [63:0] now_ts;
    } t_req;

    typedef struct packed {
        logic       status;
        logic [1:0] ts_verdict;
        logic       should_encrypt;
        logic       channel_confirmed;
        logic [1:0] session_state;
        logic       key_valid;
        logic [7:0] key_byte;
        logic       last;
    } t_rsp;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic claim;
        logic derive_init;
        logic derive_step;
        logic copy_step;
        logic stream_step;
        logic expire_step;
        logic apply;
        logic out_load;
        logic out_key;
        logic ctr_clr;
    } t_cmd_bus;

    // Datapath to controller.
    typedef struct packed {
        logic scan_done;
        logic hit;
        logic has_free;
        logic pend_set;
        logic key_set;
        logic ctr_last;
        logic rdata_ok;
    } t_sts_bus;

endpackage

/* design/sst_if.sv */
interface sst_req_if;
    logic          valid;
    logic          ready;
    sst_pkg::t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* design/sst_rsp_if.sv */
interface sst_rsp_if;
    logic          valid;
    logic          ready;
    sst_pkg::t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* design/sst_cfg_if.sv */
interface sst_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* design/sst_ctrl.sv */
module sst_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  logic              i_rsp_busy,
    input  logic [2:0]        i_cmd,
    input  sst_pkg::t_sts_bus i_sts,
    output sst_pkg::t_cmd_bus o_cmd
);

    sst_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sst_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            sst_pkg::ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load       = 1'b1;
                    o_cmd.scan_start = 1'b1;
                    n_state          = sst_pkg::ST_SEARCH;
                end
            end
            sst_pkg::ST_SEARCH: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = sst_pkg::ST_DISPATCH;
                end
            end
            sst_pkg::ST_DISPATCH: begin
                o_cmd.ctr_clr = 1'b1;
                if (i_cmd <= 3'(sst_pkg::CMD_CHECK)) begin
                    if (!i_sts.hit && !i_sts.has_free) begin
                        n_state = sst_pkg::ST_RESULT;
                    end else begin
                        o_cmd.claim = !i_sts.hit;
                        if (i_cmd == 3'(sst_pkg::CMD_NOTE) ||
                            (i_cmd == 3'(sst_pkg::CMD_CONFIRM) &&
                             !(i_sts.hit && i_sts.pend_set))) begin
                            o_cmd.derive_init = 1'b1;
                            n_state = sst_pkg::ST_DERIVE;
                        end else if (i_cmd == 3'(sst_pkg::CMD_CONFIRM)) begin
                            n_state = sst_pkg::ST_COPY;
                        end else begin
                            n_state = sst_pkg::ST_RESULT;
                        end
                    end
                end else if (i_cmd == 3'(sst_pkg::CMD_QUERY)) begin
                    if (i_sts.hit && i_sts.key_set) begin
                        n_state = sst_pkg::ST_STREAM;
                    end else begin
                        n_state = sst_pkg::ST_RESULT;
                    end
                end else if (i_cmd == 3'(sst_pkg::CMD_EXPIRE)) begin
                    n_state = sst_pkg::ST_EXPIRE;
                end else begin
                    n_state = sst_pkg::ST_RESULT;
                end
            end
            sst_pkg::ST_DERIVE: begin
                o_cmd.derive_step = 1'b1;
                if (i_sts.ctr_last) begin
                    o_cmd.ctr_clr = 1'b1;
                    n_state = (i_cmd == 3'(sst_pkg::CMD_CONFIRM)) ?
                              sst_pkg::ST_COPY : sst_pkg::ST_RESULT;
                end
            end
            sst_pkg::ST_COPY: begin
                o_cmd.copy_step = 1'b1;
                if (i_sts.ctr_last && i_sts.rdata_ok) begin
                    n_state = sst_pkg::ST_RESULT;
                end
            end
            sst_pkg::ST_STREAM: begin
                if (!i_rsp_busy) begin
                    o_cmd.stream_step = 1'b1;
                    if (i_sts.rdata_ok) begin
                        o_cmd.out_key = 1'b1;
                        if (i_sts.ctr_last) begin
                            n_state = sst_pkg::ST_IDLE;
                        end
                    end
                end
            end
            sst_pkg::ST_EXPIRE: begin
                o_cmd.expire_step = 1'b1;
                if (i_sts.ctr_last) begin
                    n_state = sst_pkg::ST_RESULT;
                end
            end
            sst_pkg::ST_RESULT: begin
                if (!i_rsp_busy) begin
                    o_cmd.apply    = 1'b1;
                    o_cmd.out_load = 1'b1;
                    n_state        = sst_pkg::ST_IDLE;
                end
            end
            default: n_state = sst_pkg::ST_IDLE;
        endcase
    end

endmodule

/* design/sst_dp.sv */
module sst_dp #(
    parameter int SESSIONS  = 16,
    parameter int KEY_BYTES = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sst_pkg::t_req     i_req,
    input  logic [31:0]       i_expire_limit,
    input  sst_pkg::t_cmd_bus i_cmd,
    output sst_pkg::t_sts_bus o_sts,
    output logic [2:0]        o_cur_cmd,
    input  logic              i_rsp_ready,
    output logic              o_rsp_valid,
    output sst_pkg::t_rsp     o_rsp
);

    localparam int EW = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
    localparam int KW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
    localparam int AW = (SESSIONS * KEY_BYTES > 1) ? $clog2(SESSIONS * KEY_BYTES) : 1;
    localparam int CW = $clog2(SESSIONS + KEY_BYTES + 1);

    logic [SESSIONS-1:0] r_used;
    logic [31:0] r_peer [SESSIONS];
    logic [63:0] r_seen [SESSIONS];
    logic [63:0] r_data [SESSIONS];
    logic [3:0]  r_flags [SESSIONS];
    logic [1:0]  r_phase [SESSIONS];

    logic [7:0] r_pend_mem [SESSIONS*KEY_BYTES];
    logic [7:0] r_act_mem [SESSIONS*KEY_BYTES];

    sst_pkg::t_req r_req;
    logic [CW-1:0] r_ctr;
    logic          r_hit, r_free_ok;
    logic [EW-1:0] r_hit_idx, r_free_idx;
    logic [31:0]   r_x;
    logic          r_rd_ok;
    logic [7:0]    r_rdata;
    logic          r_rsp_valid;
    sst_pkg::t_rsp r_rsp;
    logic          n_rsp_valid;
    sst_pkg::t_rsp n_rsp;

    logic [EW-1:0] w_e;
    logic [EW-1:0] w_scan;
    logic [KW-1:0] w_kidx;
    logic [AW-1:0] w_addr;
    logic [31:0]   w_xn;
    logic [63:0]   w_prod;
    logic [1:0]    w_verdict;
    logic          w_enc, w_conf;
    logic          w_kgo;

    assign w_e    = r_hit ? r_hit_idx : r_free_idx;
    assign w_scan = r_ctr[EW-1:0];
    assign w_kidx = r_ctr[KW-1:0];
    assign w_addr = AW'(w_e) * AW'(KEY_BYTES) + AW'(w_kidx);
    assign w_prod = {32'd0, r_x} * {32'd0, sst_pkg::LCG_MUL};
    assign w_xn   = w_prod[31:0] + sst_pkg::LCG_ADD + 32'(w_kidx);
    assign w_kgo  = i_cmd.copy_step || i_cmd.stream_step;
    assign o_cur_cmd = r_req.cmd;

    assign o_sts.scan_done = (r_ctr == CW'(SESSIONS - 1));
    assign o_sts.hit       = r_hit;
    assign o_sts.has_free  = r_free_ok;
    assign o_sts.pend_set  = r_flags[r_hit_idx][0];
    assign o_sts.key_set   = r_flags[r_hit_idx][1];
    assign o_sts.ctr_last  = i_cmd.expire_step ? (r_ctr == CW'(SESSIONS - 1)) :
                                                 (r_ctr == CW'(KEY_BYTES - 1));
    assign o_sts.rdata_ok  = r_rd_ok;

    always_comb begin
        w_verdict = sst_pkg::TV_ACCEPT;
        if (r_data[w_e] == 64'd0 || r_req.message_ts > r_data[w_e]) begin
            w_verdict = sst_pkg::TV_ACCEPT;
        end else if (r_req.message_ts == r_data[w_e]) begin
            w_verdict = sst_pkg::TV_REPLAY;
        end else begin
            w_verdict = sst_pkg::TV_ORDER;
        end
    end

    assign w_enc  = r_flags[w_e][1] && r_flags[w_e][2];
    assign w_conf = r_flags[w_e][3];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.scan_start || i_cmd.ctr_clr) begin
            r_ctr <= '0;
        end else if (i_cmd.scan_step || i_cmd.derive_step || i_cmd.expire_step ||
                     (w_kgo && r_rd_ok)) begin
            r_ctr <= r_ctr + CW'(1);
        end
        if (i_cmd.scan_start) begin
            r_hit     <= 1'b0;
            r_free_ok <= 1'b0;
        end else if (i_cmd.scan_step) begin
            if (!r_hit && r_used[w_scan] && r_peer[w_scan] == r_req.session_id) begin
                r_hit     <= 1'b1;
                r_hit_idx <= w_scan;
            end
            if (!r_free_ok && !r_used[w_scan]) begin
                r_free_ok  <= 1'b1;
                r_free_idx <= w_scan;
            end
        end
        if (i_cmd.derive_init) begin
            r_x <= r_req.session_id ^ r_req.message_ts[31:0] ^ r_req.message_ts[63:32];
        end else if (i_cmd.derive_step) begin
            r_x <= w_xn;
            r_pend_mem[w_addr] <= w_xn[31:24];
        end
        r_rdata <= i_cmd.copy_step ? r_pend_mem[w_addr] : r_act_mem[w_addr];
        if (i_cmd.copy_step && r_rd_ok) begin
            r_act_mem[w_addr] <= r_rdata;
        end
    end

    always_comb begin
        n_rsp_valid = r_rsp_valid && !i_rsp_ready;
        n_rsp       = r_rsp;
        if (i_cmd.out_load) begin
            n_rsp_valid = 1'b1;
            n_rsp       = '0;
            n_rsp.last  = 1'b1;
            if (r_req.cmd <= 3'(sst_pkg::CMD_CHECK)) begin
                if (!r_hit && !r_free_ok) begin
                    n_rsp.status = 1'b1;
                    if (r_req.cmd == 3'(sst_pkg::CMD_CHECK)) begin
                        n_rsp.ts_verdict = sst_pkg::TV_ORDER;
                    end
                end else begin
                    case (r_req.cmd)
                        3'(sst_pkg::CMD_NOTE):    n_rsp.session_state = sst_pkg::PH_PLAIN;
                        3'(sst_pkg::CMD_CONFIRM): n_rsp.session_state = sst_pkg::PH_DICT;
                        3'(sst_pkg::CMD_MARK):    n_rsp.session_state = sst_pkg::PH_SECURE;
                        default: begin
                            n_rsp.session_state = r_phase[w_e];
                            n_rsp.ts_verdict    = w_verdict;
                        end
                    endcase
                end
            end else if (r_req.cmd == 3'(sst_pkg::CMD_QUERY)) begin
                if (!r_hit) begin
                    n_rsp.status = 1'b1;
                end else begin
                    n_rsp.should_encrypt    = w_enc;
                    n_rsp.channel_confirmed = w_conf;
                    n_rsp.session_state     = r_phase[w_e];
                end
            end
        end else if (i_cmd.out_key) begin
            n_rsp_valid             = 1'b1;
            n_rsp                   = '0;
            n_rsp.should_encrypt    = w_enc;
            n_rsp.channel_confirmed = w_conf;
            n_rsp.session_state     = r_phase[w_e];
            n_rsp.key_valid         = 1'b1;
            n_rsp.key_byte          = r_rdata;
            n_rsp.last              = (r_ctr == CW'(KEY_BYTES - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ok     <= 1'b0;
            r_rsp_valid <= 1'b0;
            r_rsp       <= '0;
        end else begin
            r_rd_ok     <= w_kgo && !r_rd_ok;
            r_rsp_valid <= n_rsp_valid;
            r_rsp       <= n_rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            for (int i = 0; i < SESSIONS; i++) begin
                r_peer[i]  <= '0;
                r_seen[i]  <= '0;
                r_data[i]  <= '0;
                r_flags[i] <= '0;
                r_phase[i] <= sst_pkg::PH_INIT;
            end
        end else begin
            if (i_cmd.claim) begin
                r_used[r_free_idx]  <= 1'b1;
                r_peer[r_free_idx]  <= r_req.session_id;
                r_seen[r_free_idx]  <= '0;
                r_data[r_free_idx]  <= '0;
                r_flags[r_free_idx] <= '0;
                r_phase[r_free_idx] <= sst_pkg::PH_INIT;
            end
            if (i_cmd.derive_step && o_sts.ctr_last) begin
                r_flags[w_e][0] <= 1'b1;
            end
            if (i_cmd.expire_step && r_used[w_scan] && r_req.now_ts > r_seen[w_scan] &&
                (r_req.now_ts - r_seen[w_scan]) > {32'd0, i_expire_limit}) begin
                r_used[w_scan]  <= 1'b0;
                r_peer[w_scan]  <= '0;
                r_seen[w_scan]  <= '0;
                r_data[w_scan]  <= '0;
                r_flags[w_scan] <= '0;
                r_phase[w_scan] <= sst_pkg::PH_INIT;
            end
            if (i_cmd.apply && r_req.cmd <= 3'(sst_pkg::CMD_CHECK) &&
                (r_hit || r_free_ok)) begin
                r_seen[w_e] <= r_req.now_ts;
                case (r_req.cmd)
                    3'(sst_pkg::CMD_NOTE): r_phase[w_e] <= sst_pkg::PH_PLAIN;
                    3'(sst_pkg::CMD_CONFIRM): begin
                        r_flags[w_e][2:1] <= 2'b11;
                        r_phase[w_e]      <= sst_pkg::PH_DICT;
                    end
                    3'(sst_pkg::CMD_MARK): begin
                        r_flags[w_e][3] <= 1'b1;
                        r_phase[w_e]    <= sst_pkg::PH_SECURE;
                    end
                    default: begin
                        if (w_verdict == sst_pkg::TV_ACCEPT) begin
                            r_data[w_e] <= r_req.message_ts;
                        end
                    end
                endcase
            end
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_load || i_cmd.out_key) |-> !r_rsp_valid || i_rsp_ready)
        else $error("response overwritten");
    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({i_cmd.derive_step, i_cmd.copy_step, i_cmd.stream_step,
                    i_cmd.expire_step, i_cmd.scan_step}) <= 1)
        else $error("overlapping operations");
    a_claim_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.claim |-> r_free_ok && !r_hit)
        else $error("claim without free entry");

endmodule

/* design/secure_session_table_core.sv */
// One request at a time: a new request is accepted only while the controller is idle.
// An expire request walks every entry of the table. A query for a session with a confirmed
// key streams the key, one byte per response, with the last byte flagged; every other request
// gives a single response. The search visits one entry per cycle.
// Reset: synchronous active low; clears the session table, the expire limit returns to 86400.
module secure_session_table_core #(
    parameter int SESSIONS  = 16,
    parameter int KEY_BYTES = 32
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    sst_req_if.sink   req,
    sst_rsp_if.source rsp,
    sst_cfg_if.sink   cfg
);

    logic [31:0]       r_expire_limit;
    sst_pkg::t_cmd_bus w_cmd;
    sst_pkg::t_sts_bus w_sts;
    logic [2:0]        w_cur_cmd;

    assign cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expire_limit <= sst_pkg::EXPIRE_DEFAULT;
        end else if (cfg.valid) begin
            r_expire_limit <= (cfg.data == 32'd0) ? sst_pkg::EXPIRE_DEFAULT : cfg.data;
        end
    end

    sst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req.valid),
        .o_req_ready (req.ready),
        .i_rsp_busy  (rsp.valid && !rsp.ready),
        .i_cmd       (w_cur_cmd),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    sst_dp #(
        .SESSIONS  (SESSIONS),
        .KEY_BYTES (KEY_BYTES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (req.payload),
        .i_expire_limit (r_expire_limit),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_cur_cmd      (w_cur_cmd),
        .i_rsp_ready    (rsp.ready),
        .o_rsp_valid    (rsp.valid),
        .o_rsp          (rsp.payload)
    );

endmodule

/* verif/sst_checker.sv */
`timescale 1ns / 1ps
module sst_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  sst_pkg::t_req i_req,
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  sst_pkg::t_rsp i_rsp,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [31:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);

    localparam int SESS = 16;
    localparam int KB = 32;

    logic [31:0] limit_q;
    logic        used_q [SESS];
    logic [31:0] peer_q [SESS];
    logic [63:0] seen_q [SESS];
    logic [63:0] data_ts_q [SESS];
    logic [3:0]  flags_q [SESS];
    logic [1:0]  phase_q [SESS];
    logic [7:0]  pend_key [SESS][KB];
    logic [7:0]  act_key [SESS][KB];
    sst_pkg::t_rsp rsp_queue [$];

    assign o_pending = rsp_queue.size();

    function automatic sst_pkg::t_rsp mk(logic st, logic [1:0] tv, logic enc, logic conf,
                                         logic [1:0] ph, logic kv, logic [7:0] kb, logic lst);
        sst_pkg::t_rsp r;
        r.status = st; r.ts_verdict = tv; r.should_encrypt = enc;
        r.channel_confirmed = conf; r.session_state = ph; r.key_valid = kv;
        r.key_byte = kb; r.last = lst;
        return r;
    endfunction

    task automatic clear_slot(int e);
        used_q[e] = 0; peer_q[e] = 0; seen_q[e] = 0; data_ts_q[e] = 0;
        flags_q[e] = 0; phase_q[e] = sst_pkg::PH_INIT;
    endtask

    task automatic fill_pending(int e, logic [31:0] id, logic [63:0] ts);
        logic [31:0] x;
        x = id ^ ts[31:0] ^ ts[63:32];
        for (int i = 0; i < KB; i++) begin
            x = x * sst_pkg::LCG_MUL + sst_pkg::LCG_ADD + i;
            pend_key[e][i] = x[31:24];
        end
        flags_q[e][0] = 1'b1;
    endtask

    function automatic int find_slot(logic [31:0] id);
        for (int e = 0; e < SESS; e++)
            if (used_q[e] && peer_q[e] == id) return e;
        return -1;
    endfunction

    task automatic predict(sst_pkg::t_req q);
        int e;
        logic [1:0] v;
        logic enc, conf;
        if (q.cmd <= sst_pkg::CMD_CHECK) begin
            e = find_slot(q.session_id);
            if (e < 0) begin
                for (int k = 0; k < SESS; k++)
                    if (e < 0 && !used_q[k]) begin
                        clear_slot(k); used_q[k] = 1; peer_q[k] = q.session_id; e = k;
                    end
            end
            if (e < 0) begin
                rsp_queue.push_back(mk(1, q.cmd == sst_pkg::CMD_CHECK ? sst_pkg::TV_ORDER :
                                       sst_pkg::TV_ACCEPT, 0, 0, sst_pkg::PH_INIT, 0, 0, 1));
                return;
            end
            seen_q[e] = q.now_ts;
            v = sst_pkg::TV_ACCEPT;
            case (q.cmd)
                sst_pkg::CMD_NOTE: begin
                    fill_pending(e, q.session_id, q.message_ts);
                    phase_q[e] = sst_pkg::PH_PLAIN;
                end
                sst_pkg::CMD_CONFIRM: begin
                    if (!flags_q[e][0]) fill_pending(e, q.session_id, q.message_ts);
                    for (int i = 0; i < KB; i++) act_key[e][i] = pend_key[e][i];
                    flags_q[e] = flags_q[e] | 4'b0110;
                    phase_q[e] = sst_pkg::PH_DICT;
                end
                sst_pkg::CMD_MARK: begin
                    flags_q[e][3] = 1'b1;
                    phase_q[e] = sst_pkg::PH_SECURE;
                end
                default: begin
                    if (data_ts_q[e] == 0 || q.message_ts > data_ts_q[e])
                        data_ts_q[e] = q.message_ts;
                    else if (q.message_ts == data_ts_q[e]) v = sst_pkg::TV_REPLAY;
                    else v = sst_pkg::TV_ORDER;
                end
            endcase
            rsp_queue.push_back(mk(0, v, 0, 0, phase_q[e], 0, 0, 1));
        end else if (q.cmd == sst_pkg::CMD_QUERY) begin
            e = find_slot(q.session_id);
            if (e < 0) begin
                rsp_queue.push_back(mk(1, sst_pkg::TV_ACCEPT, 0, 0, sst_pkg::PH_INIT, 0, 0, 1));
                return;
            end
            enc = flags_q[e][1] && flags_q[e][2];
            conf = flags_q[e][3];
            if (!flags_q[e][1])
                rsp_queue.push_back(mk(0, sst_pkg::TV_ACCEPT, enc, conf, phase_q[e], 0, 0, 1));
            else
                for (int i = 0; i < KB; i++)
                    rsp_queue.push_back(mk(0, sst_pkg::TV_ACCEPT, enc, conf, phase_q[e], 1,
                                           act_key[e][i], i == KB - 1));
        end else begin
            if (q.cmd == sst_pkg::CMD_EXPIRE)
                for (int k = 0; k < SESS; k++)
                    if (used_q[k] && q.now_ts > seen_q[k] &&
                        q.now_ts - seen_q[k] > {32'd0, limit_q})
                        clear_slot(k);
            rsp_queue.push_back(mk(0, sst_pkg::TV_ACCEPT, 0, 0, sst_pkg::PH_INIT, 0, 0, 1));
        end
    endtask

    always @(posedge i_clk) begin
        sst_pkg::t_rsp exp_rsp;
        if (!i_rst_n) begin
            limit_q <= sst_pkg::EXPIRE_DEFAULT;
            for (int k = 0; k < SESS; k++) clear_slot(k);
            rsp_queue.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                limit_q <= (i_cfg_data == 0) ? sst_pkg::EXPIRE_DEFAULT : i_cfg_data;
            if (i_rsp_valid && i_rsp_ready) begin
                if (rsp_queue.size() == 0) begin
                    $display("%t unexpected response: actual %h", $realtime, i_rsp);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_rsp = rsp_queue.pop_front();
                    if (exp_rsp !== i_rsp) begin
                        $display("%t mismatch: expected %h actual %h", $realtime,
                                 exp_rsp, i_rsp);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_req_valid && i_req_ready) predict(i_req);
        end
    end
endmodule

/* verif/tb_secure_session_table_core.sv */
`timescale 1ns / 1ps
module tb_secure_session_table_core;

    logic i_clk = 0;
    logic i_rst_n = 0;
    int   errors, pending;
    bit   calm = 0;
    logic [31:0] ids [8];

    sst_req_if req ();
    sst_rsp_if rsp ();
    sst_cfg_if cfg ();

    always #1 i_clk = ~i_clk;

    secure_session_table_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .req(req.sink), .rsp(rsp.source), .cfg(cfg.sink)
    );

    sst_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(req.valid), .i_req_ready(req.ready), .i_req(req.payload),
        .i_rsp_valid(rsp.valid), .i_rsp_ready(rsp.ready), .i_rsp(rsp.payload),
        .i_cfg_valid(cfg.valid), .i_cfg_ready(cfg.ready), .i_cfg_data(cfg.data),
        .o_errors(errors), .o_pending(pending)
    );

    function automatic logic [63:0] rnd64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic send(logic [2:0] c, logic [31:0] id, logic [63:0] mts, logic [63:0] now);
        if (!calm && $urandom_range(0, 3) == 0) begin
            req.valid <= 0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        req.valid <= 1;
        req.payload <= '{cmd: c, session_id: id, message_ts: mts, now_ts: now};
        do @(posedge i_clk); while (!req.ready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        req.valid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (130) @(negedge i_clk);
    endtask

    task automatic write_limit(logic [31:0] v);
        drain();
        cfg.valid <= 1;
        cfg.data <= v;
        do @(posedge i_clk); while (!cfg.ready);
        @(negedge i_clk);
        cfg.valid <= 0;
    endtask

    task automatic rand_item(int n);
        logic [2:0] c;
        logic [31:0] id;
        c = $urandom_range(0, 19) == 0 ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
        id = ($urandom_range(0, 7) == 0) ? $urandom() : ids[$urandom_range(0, 7)];
        send(c, id, $urandom_range(0, 3) == 0 ? rnd64() : 64'($urandom_range(1, 20)),
             $urandom_range(0, 3) == 0 ? rnd64() : 64'(n * 1000));
    endtask

    always @(negedge i_clk) begin
        if (!calm && $urandom_range(0, 5) == 0) begin
            rsp.ready <= 0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        rsp.ready <= 1;
    end

    initial begin
        #4000000;
        $display("status: fail");
        $finish;
    end

    initial begin
        req.valid = 0; req.payload = '0; cfg.valid = 0; cfg.data = 0; rsp.ready = 0;
        for (int k = 0; k < 8; k++) ids[k] = $urandom();
        ids[0] = 0; ids[1] = 32'hFFFF_FFFF;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1;
        send(sst_pkg::CMD_QUERY, 32'h1, 0, 0);
        send(sst_pkg::CMD_CHECK, 32'h1, 64'd5, 64'd1);
        send(sst_pkg::CMD_CHECK, 32'h1, 64'd5, 64'd2);
        send(sst_pkg::CMD_CHECK, 32'h1, 64'd3, 64'd3);
        send(sst_pkg::CMD_QUERY, 32'h1, 0, 0);
        send(sst_pkg::CMD_NOTE, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send(sst_pkg::CMD_CONFIRM, 32'h0, 0, 0);
        send(sst_pkg::CMD_CONFIRM, 32'hFFFF_FFFF, 64'h1234_5678_9ABC_DEF0, 0);
        send(sst_pkg::CMD_MARK, 32'h0, 0, 0);
        send(sst_pkg::CMD_QUERY, 32'h0, 0, 0);
        send(3'd6, 32'h0, 0, 0);
        send(3'd7, 32'h0, 0, 0);
        for (int k = 2; k < 17; k++) send(sst_pkg::CMD_MARK, 32'h100 + k, 0, 64'd10);
        send(sst_pkg::CMD_CHECK, 32'h999, 64'd1, 64'd1);
        send(sst_pkg::CMD_NOTE, 32'h999, 64'd1, 64'd1);
        send(sst_pkg::CMD_EXPIRE, 0, 0, 64'd86411);
        send(sst_pkg::CMD_EXPIRE, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF);
        write_limit(0);
        write_limit(1);
        for (int n = 0; n < 130; n++) rand_item(n);
        write_limit(32'hFFFF_FFFF);
        for (int n = 130; n < 260; n++) rand_item(n);
        write_limit(32'd3000);
        for (int n = 260; n < 340; n++) rand_item(n);
        calm = 1;
        for (int n = 340; n < 400; n++) rand_item(n);
        drain();
        if (errors == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end
endmodule
